### rtl/bpfa_pkg.sv
// Shared constants, codes and types of the bitmap page frame allocator.
// Used by bpfa_ctrl, bpfa_dpath and bitmap_page_frame_allocator_unit.
package bpfa_pkg;

    // Bitmap geometry
    localparam int MAX_FRAMES  = 65536;
    localparam int WORD_BITS   = 64;
    localparam int WORD_COUNT  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW     = $clog2(WORD_COUNT);
    localparam int BIT_AW      = $clog2(WORD_BITS);

    // Field widths
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int FRAME_W     = 16;
    localparam int COUNT_W     = 17;
    localparam int LIMIT_W     = 17;
    localparam int PAGE_SHIFT  = 12;
    localparam int ADDR_W      = 28;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_FREE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESERVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [FRAME_W-1:0] first_frame;
        logic [COUNT_W-1:0] frame_count;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   frame_address;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic                load;
        logic                issue;
        logic                wr;
        logic                clr;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } t_ctl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              range_err;
        logic              empty;
        logic              issue_over;
        logic              clr_last;
        logic              rd_vld;
        logic              rd_last;
        logic              found;
        logic              out_free;
    } t_ctl_sts;

endpackage

### rtl/bpfa_ctrl.sv
// Sequencer of the bitmap page frame allocator: clearing pass, request
// decode, word scan and result hand-off. Depends on bpfa_pkg.
module bpfa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bpfa_pkg::t_ctl_sts i_sts,
    output bpfa_pkg::t_ctl_cmd o_cmd
);
    import bpfa_pkg::*;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_SCAN   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                is_alloc;
    logic                scan_hit;
    logic                scan_end;

    assign is_alloc = (i_sts.mode == MODE_ALLOC);
    assign scan_hit = i_sts.rd_vld && i_sts.found;
    assign scan_end = i_sts.rd_vld && i_sts.rd_last;
    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands
    always_comb begin
        n_state  = r_state;
        n_status = r_status;
        o_cmd    = '0;
        o_cmd.status = r_status;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_sts.mode == MODE_NONE) begin
                    n_status = ST_DONE;
                    n_state  = S_RESULT;
                end else if (!is_alloc && i_sts.range_err) begin
                    n_status = ST_RANGE;
                    n_state  = S_RESULT;
                end else if (i_sts.empty) begin
                    n_status = is_alloc ? ST_NO_FRAME : ST_DONE;
                    n_state  = S_RESULT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (is_alloc) begin
                    if (scan_hit) begin
                        o_cmd.wr = 1'b1;
                        n_status = ST_DONE;
                        n_state  = S_RESULT;
                    end else if (scan_end) begin
                        n_status = ST_NO_FRAME;
                        n_state  = S_RESULT;
                    end else begin
                        o_cmd.issue = !i_sts.issue_over;
                    end
                end else begin
                    o_cmd.wr = i_sts.rd_vld;
                    if (scan_end) begin
                        n_status = ST_DONE;
                        n_state  = S_RESULT;
                    end else begin
                        o_cmd.issue = !i_sts.issue_over;
                    end
                end
            end
            S_RESULT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Status register
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

    // An allocation writes one word and then stops scanning
    a_alloc_single_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.wr && is_alloc) |=> (r_state == S_RESULT))
        else $error("allocation kept scanning after its write");

    // No new request is taken while the clearing pass runs
    a_no_load_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clr |-> !o_cmd.load)
        else $error("request taken during clearing pass");

endmodule

### rtl/bpfa_dpath.sv
// Datapath of the bitmap page frame allocator: bitmap memory, word address
// counter, read-modify-write masks, first-zero search and result register.
// Depends on bpfa_pkg.
module bpfa_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  bpfa_pkg::t_in_item             i_in_data,
    input  logic                           i_cfg_valid,
    input  logic [bpfa_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  logic                           i_out_ready,
    input  bpfa_pkg::t_ctl_cmd             i_cmd,
    output bpfa_pkg::t_ctl_sts             o_sts,
    output logic                           o_out_valid,
    output bpfa_pkg::t_out_item            o_out_data
);
    import bpfa_pkg::*;

    logic [WORD_BITS-1:0] r_mem [WORD_COUNT];
    logic [WORD_BITS-1:0] r_rd_data;

    logic [LIMIT_W-1:0]   r_lim;
    logic [MODE_W-1:0]    r_mode;
    logic [FRAME_W-1:0]   r_first;
    logic [FRAME_W-1:0]   r_last;
    logic                 r_range_err;
    logic                 r_empty;
    logic [WORD_AW-1:0]   r_rd_addr;
    logic [WORD_AW-1:0]   r_rd_word;
    logic                 r_rd_vld;
    logic                 r_issue_over;
    logic [ADDR_W-1:0]    r_addr;
    logic                 r_out_valid;
    t_out_item            r_out_data;

    logic [LIMIT_W-1:0]   cfg_cap;
    logic [COUNT_W:0]     range_end;
    logic [COUNT_W:0]     range_end_m1;
    logic [LIMIT_W-1:0]   lim_m1;
    logic                 in_alloc;
    logic [WORD_AW-1:0]   first_word;
    logic [WORD_AW-1:0]   last_word;
    logic [BIT_AW-1:0]    lo_bit;
    logic [BIT_AW-1:0]    hi_bit;
    logic [WORD_BITS-1:0] word_mask;
    logic [WORD_BITS-1:0] target;
    logic [BIT_AW-1:0]    hit_idx;
    logic [WORD_BITS-1:0] rmw_data;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    // Effective limit: capped and rounded down to whole bytes
    assign cfg_cap = (i_cfg_data > LIMIT_W'(MAX_FRAMES)) ? LIMIT_W'(MAX_FRAMES) : i_cfg_data;

    // Request decode at accept
    assign in_alloc     = (i_in_data.mode == MODE_ALLOC);
    assign range_end    = (COUNT_W+1)'(i_in_data.first_frame)
                        + (COUNT_W+1)'(i_in_data.frame_count);
    assign range_end_m1 = range_end - (COUNT_W+1)'(1);
    assign lim_m1       = r_lim - LIMIT_W'(1);

    // Word bounds of the active run
    assign first_word = WORD_AW'(r_first >> BIT_AW);
    assign last_word  = WORD_AW'(r_last >> BIT_AW);

    // Mask of the frames of the returned word that lie inside the run
    assign lo_bit    = (r_rd_word == first_word) ? r_first[BIT_AW-1:0] : '0;
    assign hi_bit    = (r_rd_word == last_word) ? r_last[BIT_AW-1:0] : '1;
    assign word_mask = ({WORD_BITS{1'b1}} << lo_bit)
                     & ({WORD_BITS{1'b1}} >> (BIT_AW'(WORD_BITS - 1) - hi_bit));

    // Lowest clear frame of the word inside the run
    assign target = ~r_rd_data & word_mask;
    always_comb begin
        hit_idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (target[i]) begin
                hit_idx = BIT_AW'(i);
            end
        end
    end

    // New word value
    always_comb begin
        case (r_mode)
            MODE_ALLOC:   rmw_data = r_rd_data | (WORD_BITS'(1) << hit_idx);
            MODE_RESERVE: rmw_data = r_rd_data | word_mask;
            default:      rmw_data = r_rd_data & ~word_mask;
        endcase
    end

    assign wr_en   = i_cmd.wr | i_cmd.clr;
    assign wr_addr = i_cmd.clr ? r_rd_addr : r_rd_word;
    assign wr_data = i_cmd.clr ? {WORD_BITS{1'b1}} : rmw_data;

    // Bitmap memory, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim        <= LIMIT_W'(MAX_FRAMES);
            r_rd_addr    <= '0;
            r_rd_vld     <= 1'b0;
            r_issue_over <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_lim <= {cfg_cap[LIMIT_W-1:3], 3'b000};
            end
            r_rd_vld <= i_cmd.issue;
            if (i_cmd.load) begin
                r_rd_addr    <= in_alloc ? '0
                                         : WORD_AW'(i_in_data.first_frame >> BIT_AW);
                r_issue_over <= 1'b0;
            end else if (i_cmd.issue) begin
                r_rd_addr <= r_rd_addr + WORD_AW'(1);
                if (r_rd_addr == last_word) begin
                    r_issue_over <= 1'b1;
                end
            end else if (i_cmd.clr) begin
                r_rd_addr <= r_rd_addr + WORD_AW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode      <= i_in_data.mode;
            r_first     <= in_alloc ? '0 : i_in_data.first_frame;
            r_last      <= in_alloc ? lim_m1[FRAME_W-1:0] : range_end_m1[FRAME_W-1:0];
            r_empty     <= in_alloc ? (r_lim == '0) : (i_in_data.frame_count == '0);
            r_range_err <= range_end > (COUNT_W+1)'(r_lim);
            r_addr      <= '0;
        end else if (i_cmd.wr && (r_mode == MODE_ALLOC)) begin
            r_addr <= ADDR_W'({r_rd_word, hit_idx}) << PAGE_SHIFT;
        end
        if (i_cmd.issue) begin
            r_rd_word <= r_rd_addr;
        end
        if (i_cmd.out_load) begin
            r_out_data.status        <= i_cmd.status;
            r_out_data.frame_address <= r_addr;
        end
    end

    // Status to controller
    assign o_sts.mode       = r_mode;
    assign o_sts.range_err  = r_range_err;
    assign o_sts.empty      = r_empty;
    assign o_sts.issue_over = r_issue_over;
    assign o_sts.clr_last   = (r_rd_addr == WORD_AW'(WORD_COUNT - 1));
    assign o_sts.rd_vld     = r_rd_vld;
    assign o_sts.rd_last    = (r_rd_word == last_word);
    assign o_sts.found      = |target;
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A word write never meets a read of the same word
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && i_cmd.issue) |-> (wr_addr != r_rd_addr))
        else $error("bitmap read and write of one word in one cycle");

    // A scan write follows a returned word
    a_wr_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr |-> r_rd_vld)
        else $error("bitmap write without read data");

    // An allocation only claims a frame that was clear
    a_alloc_clear_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr && (r_mode == MODE_ALLOC)) |-> !r_rd_data[hit_idx])
        else $error("allocation claimed a used frame");

    // A result never overwrites one not yet taken
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

endmodule

### rtl/bitmap_page_frame_allocator_unit.sv
// Top level of the bitmap page frame allocator: controller plus datapath.
// Depends on bpfa_pkg, bpfa_ctrl and bpfa_dpath.
//
// One bit per 4 KiB page frame, set when the frame is used, held in a
// 1024 x 64 memory with one read and one write port. After reset a clearing
// pass writes every word to all ones, one word a cycle, and the block takes
// no request until that pass ends (configuration writes are taken at any
// time). Requests are handled one at a time: a free or reserve request
// scans the bitmap words it touches, and an allocation scans words until it
// finds a clear frame, with one memory read per cycle and a read-modify-write
// of each word; a range beyond the limit, an empty range or an unused mode
// answers without a scan. The next request is accepted while a finished
// result waits at the output.
module bitmap_page_frame_allocator_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  bpfa_pkg::t_in_item           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output bpfa_pkg::t_out_item          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bpfa_pkg::LIMIT_W-1:0] i_cfg_data
);
    import bpfa_pkg::*;

    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Limit register takes writes every cycle
    assign o_cfg_ready = 1'b1;

    bpfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bpfa_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### dv/bitmap_page_frame_allocator_unit_tb.sv
// Self-checking testbench for bitmap_page_frame_allocator_unit: a frame ledger
// class predicts each grant from the accepted requests, plain tasks drive the ports.
// Depends on bpfa_pkg and the allocator RTL.
module bitmap_page_frame_allocator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpfa_pkg::*;

    localparam int unsigned STALL_LIMIT   = 20000;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned TAIL_CYCLES   = 64;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned IDLE_PERCENT  = 35;
    localparam int          CALM_PHASE    = 1;
    localparam int          SQUEEZE_PHASE = 2;
    localparam int          PHASE_COUNT   = 9;

    // Predict grants from accepted requests and match them in order
    class frame_ledger;
        bit [WORD_BITS-1:0] bitmap [WORD_COUNT];
        bit [LIMIT_W-1:0]   limit;
        t_out_item          grant_q [$];
        int unsigned        mismatches;

        function new();
            foreach (bitmap[w]) bitmap[w] = '1;
            limit      = LIMIT_W'(MAX_FRAMES);
            mismatches = 0;
        endfunction

        function void set_limit(bit [LIMIT_W-1:0] value);
            limit = value;
        endfunction

        // Cap at the bitmap size and round down to whole bytes
        function int unsigned usable_frames();
            int unsigned lim;
            lim = (32'(limit) > MAX_FRAMES) ? MAX_FRAMES : 32'(limit);
            return lim & ~32'd7;
        endfunction

        function int unsigned pending();
            return grant_q.size();
        endfunction

        function void report(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
        endfunction

        // Apply one accepted request to the bitmap and queue its grant
        function void note_request(t_in_item rq);
            int unsigned first;
            int unsigned count;
            int unsigned lim;
            int unsigned f;
            bit [31:0]   byte_addr;
            t_out_item   res;
            first = 32'(rq.first_frame);
            count = 32'(rq.frame_count);
            lim   = usable_frames();
            res.status        = ST_DONE;
            res.frame_address = '0;
            case (rq.mode)
                MODE_FREE, MODE_RESERVE: begin
                    if (first + count > lim) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (f = first; f < first + count; f++)
                            bitmap[f / WORD_BITS][f % WORD_BITS] = (rq.mode == MODE_RESERVE);
                    end
                end
                MODE_ALLOC: begin
                    res.status = ST_NO_FRAME;
                    f = 0;
                    while (f < lim) begin
                        // skip words with every frame in use
                        if (f % WORD_BITS == 0 && f + WORD_BITS <= lim &&
                            bitmap[f / WORD_BITS] == '1) begin
                            f += WORD_BITS;
                            continue;
                        end
                        if (!bitmap[f / WORD_BITS][f % WORD_BITS]) begin
                            bitmap[f / WORD_BITS][f % WORD_BITS] = 1'b1;
                            byte_addr         = f << PAGE_SHIFT;
                            res.status        = ST_DONE;
                            res.frame_address = byte_addr[ADDR_W-1:0];
                            break;
                        end
                        f++;
                    end
                end
                default: ;
            endcase
            grant_q.push_back(res);
        endfunction

        // Compare one accepted grant with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item want;
            if (grant_q.size() == 0) begin
                report($sformatf("unexpected grant status=%0d addr=%h",
                                 got.status, got.frame_address));
                return;
            end
            want = grant_q.pop_front();
            if (got.status !== want.status)
                report($sformatf("status mismatch: expected %0d, got %0d",
                                 want.status, got.status));
            if (got.frame_address !== want.frame_address)
                report($sformatf("frame_address mismatch: expected %h, got %h",
                                 want.frame_address, got.frame_address));
        endfunction

        function void close();
            while (grant_q.size() != 0) begin
                report($sformatf("missing grant status=%0d addr=%h",
                                 grant_q[0].status, grant_q[0].frame_address));
                void'(grant_q.pop_front());
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_ready;
    t_in_item            i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [LIMIT_W-1:0]  i_cfg_data  = '0;

    frame_ledger ledger = new();

    bit          tx_calm      = 1'b0;
    bit          rx_calm      = 1'b0;
    int unsigned hold_pending = 0;
    int unsigned hold_seen    = 0;
    int unsigned hold_left    = 0;
    int unsigned quiet_cycles = 0;

    int unsigned phase_limit [PHASE_COUNT] =
        '{65536, 8, 512, 13, 131071, 3, 4101, 1000, 65536};
    int unsigned phase_items [PHASE_COUNT] =
        '{300, 150, 250, 100, 250, 40, 250, 250, 200};

    t_in_item opening [] = '{
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_FREE,    16'd0,     17'd0},
        '{MODE_FREE,    16'd0,     17'd16},
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_ALLOC,   16'hFFFF,  17'h1FFFF},
        '{MODE_FREE,    16'd65535, 17'd1},
        '{MODE_RESERVE, 16'd65535, 17'd2},
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_FREE,    16'd0,     17'd65536},
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_RESERVE, 16'd0,     17'd65536},
        '{MODE_FREE,    16'd65534, 17'd2},
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_ALLOC,   16'd0,     17'd0},
        '{MODE_NONE,    16'hFFFF,  17'h1FFFF},
        '{MODE_FREE,    16'hFFFF,  17'h1FFFF},
        '{MODE_RESERVE, 16'h5555,  17'h0AAAA},
        '{MODE_FREE,    16'hAAAA,  17'h15555}
    };

    t_in_item byte_limit_case [] = '{
        '{MODE_FREE,    16'd0, 17'd8},
        '{MODE_FREE,    16'd0, 17'd9},
        '{MODE_FREE,    16'd8, 17'd0},
        '{MODE_ALLOC,   16'd0, 17'd0},
        '{MODE_ALLOC,   16'd0, 17'd0},
        '{MODE_RESERVE, 16'd0, 17'd8},
        '{MODE_ALLOC,   16'd0, 17'd0}
    };

    bitmap_page_frame_allocator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check grants, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) ledger.check_result(o_out_data);
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (hold_seen != hold_pending) begin
            hold_seen   = hold_pending;
            hold_left   = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= rx_calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // End the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with an optional random gap first, and hold until accepted
    task automatic push_request(t_in_item rq);
        if (!tx_calm) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in_data  <= rq;
        do @(posedge i_clk); while (!o_in_ready);
        ledger.note_request(rq);
    endtask

    // Drop valid and wait for every predicted grant to arrive
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ledger.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_limit(bit [LIMIT_W-1:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        ledger.set_limit(value);
    endtask

    // Mostly well-formed ranges near the bottom of the bitmap, some noise
    function automatic t_in_item make_request(int unsigned lim);
        t_in_item    rq;
        int unsigned pick;
        int unsigned low_span;
        int unsigned first;
        int unsigned room;
        int unsigned span;
        rq.mode        = MODE_W'($urandom);
        rq.first_frame = FRAME_W'($urandom);
        rq.frame_count = COUNT_W'($urandom);
        if (lim == 0 || $urandom_range(99) < 10) return rq;
        pick = $urandom_range(99);
        rq.mode = (pick < 35) ? MODE_FREE : (pick < 55) ? MODE_RESERVE :
                  (pick < 95) ? MODE_ALLOC : MODE_NONE;
        if (rq.mode == MODE_FREE || rq.mode == MODE_RESERVE) begin
            low_span = (lim < 256) ? lim : 256;
            first = ($urandom_range(99) < 70) ? $urandom_range(low_span - 1)
                                              : $urandom_range(lim - 1);
            room = lim - first;
            pick = $urandom_range(99);
            if (pick < 5) begin
                rq.frame_count = COUNT_W'(room + 1 + $urandom_range(15));
            end else begin
                span = (pick < 80) ? 64 : (pick < 97) ? 512 : room;
                rq.frame_count = COUNT_W'($urandom_range((span < room) ? span : room));
            end
            rq.first_frame = FRAME_W'(first);
        end
        return rq;
    endfunction

    initial begin
        int p;
        int i;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests at the reset limit, then at a limit of 8
        foreach (opening[k]) push_request(opening[k]);
        write_limit(LIMIT_W'(8));
        foreach (byte_limit_case[k]) push_request(byte_limit_case[k]);

        // Random phases, one limit each
        for (p = 0; p < PHASE_COUNT; p++) begin
            write_limit(LIMIT_W'(phase_limit[p]));
            tx_calm = (p == CALM_PHASE);
            rx_calm <= (p == CALM_PHASE);
            for (i = 0; i < phase_items[p]; i++) begin
                if (p == SQUEEZE_PHASE && i == 50) begin
                    // hold the output and keep offering so the input stalls
                    hold_pending <= hold_pending + 1;
                    tx_calm = 1'b1;
                end
                if (p == SQUEEZE_PHASE && i == 80) tx_calm = 1'b0;
                if (p == SQUEEZE_PHASE && i == 120) settle();
                push_request(make_request(ledger.usable_frames()));
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        ledger.close();
        if (ledger.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/bpfa_pkg.sv
rtl/bpfa_ctrl.sv
rtl/bpfa_dpath.sv
rtl/bitmap_page_frame_allocator_unit.sv
dv/bitmap_page_frame_allocator_unit_tb.sv
